// ===== hw/rtl/rcsd_pkg.sv =====
// Shared types and constants for the RC stick command decoder.
// No dependencies; imported by the front, back and top-level modules.
package rcsd_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_STICK_LOW  = 2'd0,
        REG_STICK_HIGH = 2'd1,
        REG_AUX_CENTER = 2'd2,
        REG_HOLD_PERIOD = 2'd3
    } reg_index_t;

    // 2-bit stick position codes
    localparam logic [1:0] POS_LO = 2'b01;
    localparam logic [1:0] POS_HI = 2'b10;
    localparam logic [1:0] POS_CE = 2'b11;

    // Stick patterns, throttle in the top bits, roll in the bottom bits
    localparam logic [7:0] PAT_DISARM   = {POS_LO, POS_LO, POS_CE, POS_CE};
    localparam logic [7:0] PAT_ARM      = {POS_LO, POS_HI, POS_CE, POS_CE};
    localparam logic [7:0] PAT_TRIM_PDN = {POS_HI, POS_CE, POS_HI, POS_CE};
    localparam logic [7:0] PAT_TRIM_PUP = {POS_HI, POS_CE, POS_LO, POS_CE};
    localparam logic [7:0] PAT_TRIM_RDN = {POS_HI, POS_CE, POS_CE, POS_HI};
    localparam logic [7:0] PAT_TRIM_RUP = {POS_HI, POS_CE, POS_CE, POS_LO};
    localparam logic [7:0] PAT_LED_ON   = {POS_LO, POS_CE, POS_LO, POS_HI};
    localparam logic [7:0] PAT_LED_OFF  = {POS_LO, POS_CE, POS_LO, POS_LO};

    // Hold counter limits and aux band half width
    localparam logic [7:0]  HOLD_MAX    = 8'd250;
    localparam logic [7:0]  HOLD_FIRE   = 8'd20;
    localparam logic [7:0]  HOLD_RELOAD = 8'd10;
    localparam logic [12:0] AUX_BAND    = 13'd200;

    // Stick commands
    typedef enum logic [3:0] {
        CMD_NONE     = 4'd0,
        CMD_DISARM   = 4'd1,
        CMD_ARM      = 4'd2,
        CMD_TRIM_PDN = 4'd3,
        CMD_TRIM_PUP = 4'd4,
        CMD_TRIM_RDN = 4'd5,
        CMD_TRIM_RUP = 4'd6,
        CMD_LED_ON   = 4'd7,
        CMD_LED_OFF  = 4'd8
    } cmd_t;

    // Aux switch positions
    typedef enum logic [1:0] {
        AUX_LOW  = 2'd0,
        AUX_MID  = 2'd1,
        AUX_HIGH = 2'd2
    } aux_pos_t;

    // Configuration as seen by front and back
    typedef struct packed {
        logic [11:0] stick_low_threshold;
        logic [11:0] stick_high_threshold;
        logic [11:0] aux_center;
        logic [9:0]  hold_period_ms;
    } cfg_t;

    // Classified frame passed from front to back
    typedef struct packed {
        logic [7:0]  pattern;
        logic        throttle_down;
        logic        emergency;
        logic        aux1_low;
        aux_pos_t    aux2_pos;
        aux_pos_t    aux3_pos;
        aux_pos_t    aux4_pos;
        logic [31:0] time_ms;
    } front_item_t;

    // Mode flags
    typedef struct packed {
        logic beeper;
        logic headfree;
        logic poshold;
        logic althold;
        logic angle;
    } mode_t;

    // Result transaction
    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  pattern;
        logic        throttle_down;
        logic        emergency;
        logic        althold_setup;
        mode_t       modes;
    } result_t;

endpackage

// ===== hw/rtl/rcsd_queue.sv =====
// Small register-based FIFO used between front and back and at the output.
// Depends on nothing but its WIDTH and DEPTH parameters.
module rcsd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[head_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store the pushed transaction
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[tail_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_empty_no_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(empty && full))
        else $error("queue both empty and full");

endmodule

// ===== hw/rtl/rcsd_front.sv =====
// Front end: classifies one receiver frame into stick codes and aux positions.
// Depends on rcsd_pkg for the configuration and classified item types.
module rcsd_front
    import rcsd_pkg::*;
(
    input  cfg_t        cfg,
    input  logic [11:0] roll_value,
    input  logic [11:0] pitch_value,
    input  logic [11:0] yaw_value,
    input  logic [11:0] throttle_value,
    input  logic [11:0] aux1_value,
    input  logic [11:0] aux2_value,
    input  logic [11:0] aux3_value,
    input  logic [11:0] aux4_value,
    input  logic [31:0] time_ms,
    input  logic        is_armed,
    output front_item_t item
);

    function automatic logic [1:0] stick_code(input logic [11:0] v, input cfg_t c);
        logic [1:0] code;
        code[1] = (v > c.stick_low_threshold);
        code[0] = (v < c.stick_high_threshold);
        return code;
    endfunction

    // Band edges without signs: low when v + 200 < center, high when v > center + 200
    function automatic aux_pos_t aux_pos(input logic [11:0] v, input cfg_t c);
        aux_pos_t pos;
        if (({1'b0, v} + AUX_BAND) < {1'b0, c.aux_center})
        begin
            pos = AUX_LOW;
        end
        else if ({1'b0, v} > ({1'b0, c.aux_center} + AUX_BAND))
        begin
            pos = AUX_HIGH;
        end
        else
        begin
            pos = AUX_MID;
        end
        return pos;
    endfunction

    aux_pos_t aux1_pos;

    // Classify sticks and switches
    always_comb
    begin
        aux1_pos           = aux_pos(aux1_value, cfg);
        item.pattern       = {stick_code(throttle_value, cfg), stick_code(yaw_value, cfg),
                              stick_code(pitch_value, cfg), stick_code(roll_value, cfg)};
        item.throttle_down = (throttle_value < cfg.stick_low_threshold);
        item.emergency     = (aux1_pos == AUX_HIGH) && is_armed;
        item.aux1_low      = (aux1_pos == AUX_LOW);
        item.aux2_pos      = aux_pos(aux2_value, cfg);
        item.aux3_pos      = aux_pos(aux3_value, cfg);
        item.aux4_pos      = aux_pos(aux4_value, cfg);
        item.time_ms       = time_ms;
    end

endmodule

// ===== hw/rtl/rcsd_back.sv =====
// Back end: hold counter, stick command decode and mode flag update.
// Depends on rcsd_pkg; fed from the front queue, feeds the output queue.
module rcsd_back
    import rcsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  front_item_t item,
    input  logic        item_valid,
    output logic        item_take,
    input  logic        res_full,
    output result_t     res
);

    logic [7:0]  prev_pattern_reg, prev_pattern_next;
    logic [7:0]  hold_count_reg, hold_count_next;
    logic [31:0] last_step_time_reg, last_step_time_next;
    mode_t       mode_flags_reg, mode_flags_next;

    logic        same;
    logic [31:0] elapsed;
    logic        step;
    logic [7:0]  hold_stepped;
    cmd_t        cmd;
    logic        setup;

    assign item_take = item_valid && !res_full;

    // Step the hold counter, decode the command, update mode flags
    always_comb
    begin
        prev_pattern_next   = prev_pattern_reg;
        hold_count_next     = hold_count_reg;
        last_step_time_next = last_step_time_reg;
        mode_flags_next     = mode_flags_reg;
        cmd                 = CMD_NONE;
        setup               = 1'b0;

        same         = (item.pattern == prev_pattern_reg);
        elapsed      = item.time_ms - last_step_time_reg;
        step         = same && (hold_count_reg < HOLD_MAX)
                       && (elapsed >= {22'd0, cfg.hold_period_ms});
        hold_stepped = !same ? 8'd0 : (step ? hold_count_reg + 8'd1 : hold_count_reg);

        if (item_take)
        begin
            prev_pattern_next = item.pattern;
            hold_count_next   = hold_stepped;
            if (step)
            begin
                last_step_time_next = item.time_ms;
            end

            if (hold_stepped == HOLD_FIRE)
            begin
                case (item.pattern)
                    PAT_DISARM:   cmd = CMD_DISARM;
                    PAT_ARM:      cmd = item.aux1_low ? CMD_ARM : CMD_NONE;
                    PAT_TRIM_PDN:
                    begin
                        cmd             = CMD_TRIM_PDN;
                        hold_count_next = HOLD_RELOAD;
                    end
                    PAT_TRIM_PUP:
                    begin
                        cmd             = CMD_TRIM_PUP;
                        hold_count_next = HOLD_RELOAD;
                    end
                    PAT_TRIM_RDN:
                    begin
                        cmd             = CMD_TRIM_RDN;
                        hold_count_next = HOLD_RELOAD;
                    end
                    PAT_TRIM_RUP:
                    begin
                        cmd             = CMD_TRIM_RUP;
                        hold_count_next = HOLD_RELOAD;
                    end
                    PAT_LED_ON:   cmd = CMD_LED_ON;
                    PAT_LED_OFF:  cmd = CMD_LED_OFF;
                    default:      cmd = CMD_NONE;
                endcase
            end

            // Flight mode switch
            case (item.aux3_pos)
                AUX_LOW:
                begin
                    mode_flags_next.angle   = 1'b1;
                    mode_flags_next.althold = 1'b0;
                    mode_flags_next.poshold = 1'b0;
                end
                AUX_MID:
                begin
                    if (!mode_flags_reg.althold)
                    begin
                        mode_flags_next.althold = 1'b1;
                        setup                   = 1'b1;
                    end
                    mode_flags_next.poshold = 1'b0;
                end
                AUX_HIGH: mode_flags_next.poshold = 1'b1;
                default:  mode_flags_next.poshold = mode_flags_reg.poshold;
            endcase

            // Headfree and beeper switches hold their flags at center
            case (item.aux4_pos)
                AUX_LOW:  mode_flags_next.headfree = 1'b0;
                AUX_HIGH: mode_flags_next.headfree = 1'b1;
                default:  mode_flags_next.headfree = mode_flags_reg.headfree;
            endcase
            case (item.aux2_pos)
                AUX_LOW:  mode_flags_next.beeper = 1'b0;
                AUX_HIGH: mode_flags_next.beeper = 1'b1;
                default:  mode_flags_next.beeper = mode_flags_reg.beeper;
            endcase
        end

        res.cmd           = cmd;
        res.pattern       = item.pattern;
        res.throttle_down = item.throttle_down;
        res.emergency     = item.emergency;
        res.althold_setup = setup;
        res.modes         = mode_flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pattern_reg   <= '0;
            hold_count_reg     <= '0;
            last_step_time_reg <= '0;
            mode_flags_reg     <= '0;
        end
        else
        begin
            prev_pattern_reg   <= prev_pattern_next;
            hold_count_reg     <= hold_count_next;
            last_step_time_reg <= last_step_time_next;
            mode_flags_reg     <= mode_flags_next;
        end
    end

    a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hold_count_reg <= HOLD_MAX)
        else $error("hold counter above saturation");

    a_trim_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && (cmd == CMD_TRIM_PDN || cmd == CMD_TRIM_PUP
                       || cmd == CMD_TRIM_RDN || cmd == CMD_TRIM_RUP))
        |=> (hold_count_reg == HOLD_RELOAD))
        else $error("trim did not reload hold counter");

    a_setup_sets_alt: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && setup) |=> (mode_flags_reg.althold && !$past(mode_flags_reg.althold)))
        else $error("althold setup pulse without althold rising");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !item_take |=> $stable(hold_count_reg) && $stable(mode_flags_reg))
        else $error("state changed without a transaction");

endmodule

// ===== hw/rtl/rc_stick_command_decoder.sv =====
// RC stick command decoder, top level: config registers, front, queues, back.
// A frame from the front queue is decoded by the back end and its result registered in
// the output queue; the back end takes one frame per cycle while that queue is not full.
// Up to QUEUE_DEPTH frames buffer between front and back, two results at the output.
// Reset: asynchronous active low; config returns to 1100/1900/1500/20, state clears.
// Depends on rcsd_pkg, rcsd_front, rcsd_queue and rcsd_back.
module rc_stick_command_decoder
    import rcsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [11:0] roll_value,
    input  logic [11:0] pitch_value,
    input  logic [11:0] yaw_value,
    input  logic [11:0] throttle_value,
    input  logic [11:0] aux1_value,
    input  logic [11:0] aux2_value,
    input  logic [11:0] aux3_value,
    input  logic [11:0] aux4_value,
    input  logic [31:0] time_ms,
    input  logic        is_armed,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  stick_command,
    output logic [7:0]  stick_pattern,
    output logic        throttle_down,
    output logic        emergency_disarm,
    output logic        althold_setup,
    output logic        self_level_mode,
    output logic        althold_mode,
    output logic        poshold_mode,
    output logic        heading_free_mode,
    output logic        beeper_mode
);

    localparam int ITEM_W    = $bits(front_item_t);
    localparam int RESULT_W  = $bits(result_t);
    localparam int OUT_DEPTH = 2;

    cfg_t        cfg_reg, cfg_next;
    front_item_t front_item;
    front_item_t mid_item;
    logic        mid_empty;
    logic        mid_take;
    result_t     back_res;
    logic        out_full;
    result_t     out_res;

    // Write configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_STICK_LOW:   cfg_next.stick_low_threshold  = cfg_data;
                REG_STICK_HIGH:  cfg_next.stick_high_threshold = cfg_data;
                REG_AUX_CENTER:  cfg_next.aux_center           = cfg_data;
                REG_HOLD_PERIOD: cfg_next.hold_period_ms       = cfg_data[9:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_low_threshold  <= 12'd1100;
            cfg_reg.stick_high_threshold <= 12'd1900;
            cfg_reg.aux_center           <= 12'd1500;
            cfg_reg.hold_period_ms       <= 10'd20;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rcsd_front u_front (
        .cfg            (cfg_reg),
        .roll_value     (roll_value),
        .pitch_value    (pitch_value),
        .yaw_value      (yaw_value),
        .throttle_value (throttle_value),
        .aux1_value     (aux1_value),
        .aux2_value     (aux2_value),
        .aux3_value     (aux3_value),
        .aux4_value     (aux4_value),
        .time_ms        (time_ms),
        .is_armed       (is_armed),
        .item           (front_item)
    );

    rcsd_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (full),
        .pop   (mid_take),
        .rdata (mid_item),
        .empty (mid_empty)
    );

    rcsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (mid_item),
        .item_valid (!mid_empty),
        .item_take  (mid_take),
        .res_full   (out_full),
        .res        (back_res)
    );

    rcsd_queue #(
        .WIDTH (RESULT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_take),
        .wdata (back_res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    // Drive result ports from the oldest waiting transaction
    assign stick_command     = out_res.cmd;
    assign stick_pattern     = out_res.pattern;
    assign throttle_down     = out_res.throttle_down;
    assign emergency_disarm  = out_res.emergency;
    assign althold_setup     = out_res.althold_setup;
    assign self_level_mode   = out_res.modes.angle;
    assign althold_mode      = out_res.modes.althold;
    assign poshold_mode      = out_res.modes.poshold;
    assign heading_free_mode = out_res.modes.headfree;
    assign beeper_mode       = out_res.modes.beeper;

endmodule

// ===== sim/rcsd_frame_checker.sv =====
`timescale 1ns / 1ps
// Frame checker for rc_stick_command_decoder: mirrors the stick and aux decode,
// queues the expected result of each accepted frame and compares every popped one.
// Depends on rcsd_pkg for the command, aux position, mode and result types.
module rcsd_frame_checker
    import rcsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [11:0] roll_value,
    input  logic [11:0] pitch_value,
    input  logic [11:0] yaw_value,
    input  logic [11:0] throttle_value,
    input  logic [11:0] aux1_value,
    input  logic [11:0] aux2_value,
    input  logic [11:0] aux3_value,
    input  logic [11:0] aux4_value,
    input  logic [31:0] time_ms,
    input  logic        is_armed,
    input  logic        empty,
    input  logic        pop,
    input  logic [3:0]  stick_command,
    input  logic [7:0]  stick_pattern,
    input  logic        throttle_down,
    input  logic        emergency_disarm,
    input  logic        althold_setup,
    input  logic        self_level_mode,
    input  logic        althold_mode,
    input  logic        poshold_mode,
    input  logic        heading_free_mode,
    input  logic        beeper_mode,
    output int          fail_count,
    output int          frames_open
);

    // Stick position codes, as the decode table sees them
    localparam logic [1:0] STK_LO = 2'b01;
    localparam logic [1:0] STK_HI = 2'b10;
    localparam logic [1:0] STK_CE = 2'b11;

    // Command patterns, {throttle, yaw, pitch, roll}
    localparam logic [7:0] SEQ_DISARM   = {STK_LO, STK_LO, STK_CE, STK_CE};
    localparam logic [7:0] SEQ_ARM      = {STK_LO, STK_HI, STK_CE, STK_CE};
    localparam logic [7:0] SEQ_PITCH_DN = {STK_HI, STK_CE, STK_HI, STK_CE};
    localparam logic [7:0] SEQ_PITCH_UP = {STK_HI, STK_CE, STK_LO, STK_CE};
    localparam logic [7:0] SEQ_ROLL_DN  = {STK_HI, STK_CE, STK_CE, STK_HI};
    localparam logic [7:0] SEQ_ROLL_UP  = {STK_HI, STK_CE, STK_CE, STK_LO};
    localparam logic [7:0] SEQ_LED_ON   = {STK_LO, STK_CE, STK_LO, STK_HI};
    localparam logic [7:0] SEQ_LED_OFF  = {STK_LO, STK_CE, STK_LO, STK_LO};

    localparam logic [7:0] HOLD_LIMIT  = 8'd250;
    localparam logic [7:0] HOLD_TRIGGER = 8'd20;
    localparam logic [7:0] HOLD_REARM  = 8'd10;
    localparam int         AUX_HALF_BAND = 200;

    localparam logic [11:0] DEF_LOW_THR    = 12'd1100;
    localparam logic [11:0] DEF_HIGH_THR   = 12'd1900;
    localparam logic [11:0] DEF_AUX_CENTER = 12'd1500;
    localparam logic [9:0]  DEF_PERIOD     = 10'd20;

    // Configuration copy
    logic [11:0] low_thr;
    logic [11:0] high_thr;
    logic [11:0] aux_center;
    logic [9:0]  period_ms;

    // Decoder state copy
    logic [7:0]  last_pat;
    logic [7:0]  hold_cnt;
    logic [31:0] step_time;
    mode_t       flags;

    result_t     decoded_q[$];
    result_t     head;
    int          mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [1:0] stick_zone(logic [11:0] v);
        return {v > low_thr, v < high_thr};
    endfunction

    // Band limits are signed, so a center near either end can hide a position
    function automatic aux_pos_t aux_zone(logic [11:0] v);
        int x;
        int c;
        x = int'(v);
        c = int'(aux_center);
        if (x < c - AUX_HALF_BAND)
            return AUX_LOW;
        if (x > c + AUX_HALF_BAND)
            return AUX_HIGH;
        return AUX_MID;
    endfunction

    // Advance the decoder state by one frame and return its result
    function automatic result_t decode_frame(
        logic [11:0] roll, logic [11:0] pitch, logic [11:0] yaw, logic [11:0] thr,
        logic [11:0] a1v, logic [11:0] a2v, logic [11:0] a3v, logic [11:0] a4v,
        logic [31:0] now, logic armed
    );
        result_t  r;
        logic [7:0] pat;
        aux_pos_t z1;
        aux_pos_t z2;
        aux_pos_t z3;
        aux_pos_t z4;
        r = '0;
        z1 = aux_zone(a1v);
        z2 = aux_zone(a2v);
        z3 = aux_zone(a3v);
        z4 = aux_zone(a4v);
        pat = {stick_zone(thr), stick_zone(yaw), stick_zone(pitch), stick_zone(roll)};

        // Step the hold counter once per elapsed period while the pattern holds
        if (pat == last_pat)
        begin
            if (hold_cnt < HOLD_LIMIT && (now - step_time) >= period_ms)
            begin
                step_time = now;
                hold_cnt = hold_cnt + 8'd1;
            end
        end
        else
        begin
            hold_cnt = '0;
        end
        last_pat = pat;

        // Decode the command; trims drop the count back to rearm
        r.cmd = CMD_NONE;
        if (hold_cnt == HOLD_TRIGGER)
        begin
            case (pat)
                SEQ_DISARM: r.cmd = CMD_DISARM;
                SEQ_ARM: r.cmd = (z1 == AUX_LOW) ? CMD_ARM : CMD_NONE;
                SEQ_PITCH_DN:
                begin
                    r.cmd = CMD_TRIM_PDN;
                    hold_cnt = HOLD_REARM;
                end
                SEQ_PITCH_UP:
                begin
                    r.cmd = CMD_TRIM_PUP;
                    hold_cnt = HOLD_REARM;
                end
                SEQ_ROLL_DN:
                begin
                    r.cmd = CMD_TRIM_RDN;
                    hold_cnt = HOLD_REARM;
                end
                SEQ_ROLL_UP:
                begin
                    r.cmd = CMD_TRIM_RUP;
                    hold_cnt = HOLD_REARM;
                end
                SEQ_LED_ON: r.cmd = CMD_LED_ON;
                SEQ_LED_OFF: r.cmd = CMD_LED_OFF;
                default: r.cmd = CMD_NONE;
            endcase
        end

        // Flight mode switch; entering altitude hold raises the setup pulse
        if (z3 == AUX_LOW)
        begin
            flags.angle = 1'b1;
            flags.althold = 1'b0;
            flags.poshold = 1'b0;
        end
        else if (z3 == AUX_MID)
        begin
            if (!flags.althold)
            begin
                flags.althold = 1'b1;
                r.althold_setup = 1'b1;
            end
            flags.poshold = 1'b0;
        end
        else
        begin
            flags.poshold = 1'b1;
        end

        // Headfree and beeper hold their flag in the center position
        if (z4 == AUX_LOW)
            flags.headfree = 1'b0;
        else if (z4 == AUX_HIGH)
            flags.headfree = 1'b1;
        if (z2 == AUX_LOW)
            flags.beeper = 1'b0;
        else if (z2 == AUX_HIGH)
            flags.beeper = 1'b1;

        r.pattern = pat;
        r.throttle_down = thr < low_thr;
        r.emergency = (z1 == AUX_HIGH) && armed;
        r.modes = flags;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare popped results, predict accepted frames, track register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr = DEF_LOW_THR;
            high_thr = DEF_HIGH_THR;
            aux_center = DEF_AUX_CENTER;
            period_ms = DEF_PERIOD;
            last_pat = '0;
            hold_cnt = '0;
            step_time = '0;
            flags = '0;
            decoded_q.delete();
            frames_open <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("result popped with no frame outstanding");
                    mismatches++;
                end
                else
                begin
                    head = decoded_q.pop_front();
                    check_field("stick_command", 8'(head.cmd), 8'(stick_command));
                    check_field("stick_pattern", head.pattern, stick_pattern);
                    check_field("throttle_down", 8'(head.throttle_down),
                                8'(throttle_down));
                    check_field("emergency_disarm", 8'(head.emergency),
                                8'(emergency_disarm));
                    check_field("althold_setup", 8'(head.althold_setup),
                                8'(althold_setup));
                    check_field("self_level_mode", 8'(head.modes.angle),
                                8'(self_level_mode));
                    check_field("althold_mode", 8'(head.modes.althold), 8'(althold_mode));
                    check_field("poshold_mode", 8'(head.modes.poshold), 8'(poshold_mode));
                    check_field("heading_free_mode", 8'(head.modes.headfree),
                                8'(heading_free_mode));
                    check_field("beeper_mode", 8'(head.modes.beeper), 8'(beeper_mode));
                end
            end
            if (push && !full)
            begin
                decoded_q.push_back(decode_frame(roll_value, pitch_value, yaw_value,
                    throttle_value, aux1_value, aux2_value, aux3_value, aux4_value,
                    time_ms, is_armed));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STICK_LOW: low_thr = cfg_data;
                    REG_STICK_HIGH: high_thr = cfg_data;
                    REG_AUX_CENTER: aux_center = cfg_data;
                    REG_HOLD_PERIOD: period_ms = cfg_data[9:0];
                    default: ;
                endcase
            end
            frames_open <= decoded_q.size();
        end
    end

endmodule

// ===== sim/tb_rc_stick_command_decoder.sv =====
`timescale 1ns / 1ps
// Testbench top for rc_stick_command_decoder: drives frames and register writes,
// drains results with random stalls. Depends on rcsd_pkg, the block and rcsd_frame_checker.
module tb_rc_stick_command_decoder;
    import rcsd_pkg::*;

    typedef struct packed {
        logic [11:0] roll;
        logic [11:0] pitch;
        logic [11:0] yaw;
        logic [11:0] thr;
        logic [11:0] aux1;
        logic [11:0] aux2;
        logic [11:0] aux3;
        logic [11:0] aux4;
        logic [31:0] stamp;
        logic        armed;
    } frame_t;

    typedef enum int { DRAIN, COIN, TRICKLE, CADENCE } drain_style_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        push;
    logic        full;
    logic [11:0] roll_value;
    logic [11:0] pitch_value;
    logic [11:0] yaw_value;
    logic [11:0] throttle_value;
    logic [11:0] aux1_value;
    logic [11:0] aux2_value;
    logic [11:0] aux3_value;
    logic [11:0] aux4_value;
    logic [31:0] time_ms;
    logic        is_armed;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  stick_command;
    logic [7:0]  stick_pattern;
    logic        throttle_down;
    logic        emergency_disarm;
    logic        althold_setup;
    logic        self_level_mode;
    logic        althold_mode;
    logic        poshold_mode;
    logic        heading_free_mode;
    logic        beeper_mode;

    int fail_total;
    int frames_in_flight;

    // Stimulus-side copy of the thresholds, used to aim stick and aux values
    int          lo_thr = 1100;
    int          hi_thr = 1900;
    int          aux_mid = 1500;
    int          period = 20;
    logic [31:0] now_ms = '0;
    int          sent = 0;
    int          burst_left = 0;

    drain_style_t drain_style = DRAIN;
    int           style_left = 0;
    int           cyc = 0;

    rc_stick_command_decoder DUT (.*);

    rcsd_frame_checker frame_check (
        .fail_count(fail_total),
        .frames_open(frames_in_flight),
        .*
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("tb_rc_stick_command_decoder: errors");
        $finish;
    end

    // Result side: switch between drain styles every so often
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            drain_style = drain_style_t'($urandom_range(0, 3));
            style_left = $urandom_range(20, 150);
        end
        else
        begin
            style_left--;
        end
        cyc++;
        case (drain_style)
            DRAIN: pop <= 1'b1;
            COIN: pop <= 1'($urandom_range(0, 1));
            TRICKLE: pop <= ($urandom_range(0, 7) == 0);
            default: pop <= (cyc % 12) < 7;
        endcase
    end

    // Pick a stick value that lands in the requested code, or anything if none can
    function automatic logic [11:0] stick_for(logic [1:0] code);
        int a;
        int b;
        case (code)
            POS_LO:
            begin
                a = 0;
                b = (lo_thr < hi_thr - 1) ? lo_thr : hi_thr - 1;
            end
            POS_HI:
            begin
                a = (lo_thr + 1 > hi_thr) ? lo_thr + 1 : hi_thr;
                b = 4095;
            end
            POS_CE:
            begin
                a = lo_thr + 1;
                b = hi_thr - 1;
            end
            default:
            begin
                a = hi_thr;
                b = lo_thr;
            end
        endcase
        if (a > b)
            return 12'($urandom_range(4095, 0));
        case ($urandom_range(0, 7))
            0: return 12'(a);
            1: return 12'(b);
            default: return 12'($urandom_range(b, a));
        endcase
    endfunction

    // Pick an aux value in the requested position, falling back to center
    function automatic logic [11:0] aux_for(aux_pos_t z);
        int a;
        int b;
        case (z)
            AUX_LOW:
            begin
                a = 0;
                b = aux_mid - int'(AUX_BAND) - 1;
            end
            AUX_HIGH:
            begin
                a = aux_mid + int'(AUX_BAND) + 1;
                b = 4095;
            end
            default:
            begin
                a = aux_mid - int'(AUX_BAND);
                b = aux_mid + int'(AUX_BAND);
            end
        endcase
        if (a < 0)
            a = 0;
        if (b > 4095)
            b = 4095;
        if (a > b)
            return aux_for(AUX_MID);
        case ($urandom_range(0, 7))
            0: return 12'(a);
            1: return 12'(b);
            default: return 12'($urandom_range(b, a));
        endcase
    endfunction

    // Present one frame and hold it until accepted; idle between bursts
    task automatic send_frame(frame_t f);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        roll_value <= f.roll;
        pitch_value <= f.pitch;
        yaw_value <= f.yaw;
        throttle_value <= f.thr;
        aux1_value <= f.aux1;
        aux2_value <= f.aux2;
        aux3_value <= f.aux3;
        aux4_value <= f.aux4;
        time_ms <= f.stamp;
        is_armed <= f.armed;
        push <= 1'b1;
        do @(posedge clk); while (full);
        sent++;
    endtask

    // Stop sending and wait for every outstanding result, plus the pipeline depth
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (frames_in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(reg_index_t idx, logic [11:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Write all four registers back to back; only called while idle
    task automatic program_cfg(int lo, int hi, int mid, int per);
        put_reg(REG_STICK_LOW, 12'(lo));
        put_reg(REG_STICK_HIGH, 12'(hi));
        put_reg(REG_AUX_CENTER, 12'(mid));
        put_reg(REG_HOLD_PERIOD, 12'(per));
        cfg_we <= 1'b0;
        lo_thr = lo;
        hi_thr = hi;
        aux_mid = mid;
        period = per & 1023;
    endtask

    // Hold one stick pattern for a run of frames, with pacing and aux drift
    task automatic hold_sequence(int len);
        logic [7:0] pat;
        aux_pos_t   z[4];
        logic       armed;
        int         pace;
        frame_t     f;
        case ($urandom_range(0, 9))
            0: pat = PAT_DISARM;
            1: pat = PAT_ARM;
            2: pat = PAT_TRIM_PDN;
            3: pat = PAT_TRIM_PUP;
            4: pat = PAT_TRIM_RDN;
            5: pat = PAT_TRIM_RUP;
            6: pat = PAT_LED_ON;
            7: pat = PAT_LED_OFF;
            default: pat = 8'($urandom);
        endcase
        z[0] = ($urandom_range(0, 9) < 7) ? AUX_LOW : aux_pos_t'($urandom_range(0, 2));
        for (int k = 1; k < 4; k++)
            z[k] = aux_pos_t'($urandom_range(0, 2));
        armed = 1'($urandom_range(0, 1));
        pace = $urandom_range(0, 2);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                z[$urandom_range(0, 3)] = aux_pos_t'($urandom_range(0, 2));
            if ($urandom_range(0, 15) == 0)
                armed = ~armed;
            f.roll = stick_for(pat[1:0]);
            f.pitch = stick_for(pat[3:2]);
            f.yaw = stick_for(pat[5:4]);
            f.thr = stick_for(pat[7:6]);
            f.aux1 = aux_for(z[0]);
            f.aux2 = aux_for(z[1]);
            f.aux3 = aux_for(z[2]);
            f.aux4 = aux_for(z[3]);
            f.stamp = now_ms;
            f.armed = armed;
            send_frame(f);
            // Advance time: exact period, slightly late, or sometimes short of it
            case (pace)
                0: now_ms = now_ms + period;
                1: now_ms = now_ms + period + $urandom_range(0, 3);
                default: now_ms = now_ms + (($urandom_range(0, 3) == 0) ?
                                            $urandom_range(period, 0) : period);
            endcase
        end
    endtask

    // Mostly full hold runs, some broken runs, some raw noise frames
    task automatic random_phase(int n);
        int           goal;
        logic [159:0] noise;
        goal = sent + n;
        while (sent < goal)
        begin
            if ($urandom_range(0, 19) == 0)
                now_ms = ($urandom_range(0, 1) == 1) ? $urandom
                                                     : 32'hFFFF_FFFF - $urandom_range(600, 0);
            case ($urandom_range(0, 9))
                7, 8: hold_sequence($urandom_range(19, 2));
                9:
                begin
                    repeat ($urandom_range(5, 1))
                    begin
                        noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
                        send_frame(noise[$bits(frame_t)-1:0]);
                    end
                end
                default: hold_sequence(($urandom_range(0, 5) == 0) ? $urandom_range(70, 36)
                                                                  : $urandom_range(35, 18));
            endcase
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_STICK_LOW;
        cfg_data <= '0;
        roll_value <= '0;
        pitch_value <= '0;
        yaw_value <= '0;
        throttle_value <= '0;
        aux1_value <= '0;
        aux2_value <= '0;
        aux3_value <= '0;
        aux4_value <= '0;
        time_ms <= '0;
        is_armed <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at reset thresholds: field extremes, band edges, mode switching
        send_frame({12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 1'b0});
        send_frame({12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                    12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1});
        send_frame({12'd1100, 12'd1101, 12'd1899, 12'd1900, 12'd1299, 12'd1300,
                    12'd1700, 12'd1701, 32'd20, 1'b1});
        send_frame({12'd1101, 12'd1100, 12'd1900, 12'd1899, 12'd1701, 12'd1700,
                    12'd1300, 12'd1299, 32'd40, 1'b1});
        send_frame({12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd1500,
                    12'd1500, 12'd1500, 32'd60, 1'b0});
        send_frame({12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd1500,
                    12'd1000, 12'd1500, 32'd80, 1'b0});
        send_frame({12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd1500,
                    12'd1500, 12'd1500, 32'd100, 1'b0});
        send_frame({12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd2000,
                    12'd2000, 12'd2000, 32'd120, 1'b1});
        send_frame({12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd1500,
                    12'd1500, 12'd1500, 32'd140, 1'b1});
        send_frame({12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd2000, 12'd1000,
                    12'd2000, 12'd1000, 32'd160, 1'b0});
        send_frame({12'd2048, 12'd2048, 12'd1100, 12'd1100, 12'd1000, 12'd1500,
                    12'd1000, 12'd1500, 32'hFFFF_FFF0, 1'b0});
        send_frame({12'd2048, 12'd2048, 12'd1100, 12'd1100, 12'd1000, 12'd1500,
                    12'd1000, 12'd1500, 32'h0000_0004, 1'b0});
        send_frame({12'd2048, 12'd2048, 12'd1100, 12'd1100, 12'd1000, 12'd1500,
                    12'd1000, 12'd1500, 32'h0000_0004, 1'b1});
        send_frame({12'd4095, 12'd0, 12'd2048, 12'd0, 12'd2048, 12'd0, 12'd4095,
                    12'd0, 32'h5555_AAAA, 1'b1});
        send_frame({12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0,
                    12'd4095, 32'hAAAA_5555, 1'b0});
        now_ms = 32'd200;

        random_phase(150);
        settle();

        // Widest code ranges, aux center at the bottom, counter steps every frame
        program_cfg(0, 4095, 0, 0);
        random_phase(150);
        settle();

        // Inverted thresholds, aux center at the top, longest period via masked write
        program_cfg(4095, 0, 4095, 4095);
        random_phase(120);
        settle();

        program_cfg($urandom_range(1400, 700), $urandom_range(2400, 1600),
                    $urandom_range(3000, 1000), $urandom_range(60, 1));
        random_phase(160);
        settle();

        program_cfg(200, 3900, 150, 5);
        random_phase(150);
        settle();

        program_cfg(1100, 1900, 1500, 1);
        random_phase(150);
        settle();

        if (fail_total == 0)
            $display("tb_rc_stick_command_decoder: clean");
        else
            $display("tb_rc_stick_command_decoder: errors");
        $finish;
    end

endmodule
